FILE: rtl/core/pip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon test.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 24;
	localparam int IDX_BITS     = $clog2(MAX_VERTICES);
	localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int PROD_BITS    = 2 * DIFF_BITS;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} vertex_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} edge_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLOSE,
		ST_DRAIN
	} pip_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/pip_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_cell
// One vertex cell of the rotating vertex ring: loads on a write, shifts on a scan.
// ----------------------------------------------------------------------------
module pip_cell
	import pip_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    load_en,
	input  wire vertex_t load_data,
	input  wire logic    shift_en,
	input  wire vertex_t shift_in,
	output vertex_t      vertex_q
);

	always_ff @(posedge clk) begin
		if (load_en) begin
			vertex_q <= load_data;
		end else if (shift_en) begin
			vertex_q <= shift_in;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/pip_edge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_edge
// Pipelined edge crossing test with exact cross-multiplication and parity.
// ----------------------------------------------------------------------------
module pip_edge
	import pip_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire edge_ctl_t              ctl,
	input  wire vertex_t                vert_i,
	input  wire vertex_t                vert_j,
	input  wire logic signed [COORD_BITS-1:0] px,
	input  wire logic signed [COORD_BITS-1:0] py,
	output logic                        parity_q
);

	logic signed [DIFF_BITS-1:0] dy;
	logic signed [DIFF_BITS-1:0] ady;
	logic signed [DIFF_BITS-1:0] t;
	logic signed [DIFF_BITS-1:0] dx;
	logic signed [DIFF_BITS-1:0] ex;
	logic                        straddle;

	logic                        valid_s1;
	logic signed [DIFF_BITS-1:0] dx_s1;
	logic signed [DIFF_BITS-1:0] ady_s1;
	logic signed [DIFF_BITS-1:0] ex_s1;
	logic signed [DIFF_BITS-1:0] t_s1;

	logic                        valid_s2;
	logic signed [PROD_BITS-1:0] p1_s2;
	logic signed [PROD_BITS-1:0] p2_s2;

	always_comb begin
		straddle = (vert_i.y > py) != (vert_j.y > py);
		dy  = DIFF_BITS'(vert_j.y) - DIFF_BITS'(vert_i.y);
		ady = dy[DIFF_BITS-1] ? -dy : dy;
		t   = dy[DIFF_BITS-1] ? DIFF_BITS'(vert_i.y) - DIFF_BITS'(py)
		                      : DIFF_BITS'(py) - DIFF_BITS'(vert_i.y);
		dx  = DIFF_BITS'(px) - DIFF_BITS'(vert_i.x);
		ex  = DIFF_BITS'(vert_j.x) - DIFF_BITS'(vert_i.x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			parity_q <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid && straddle;
			valid_s2 <= valid_s1;
			if (ctl.clear) begin
				parity_q <= 1'b0;
			end else if (valid_s2 && (p1_s2 < p2_s2)) begin
				parity_q <= ~parity_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= dx;
		ady_s1 <= ady;
		ex_s1  <= ex;
		t_s1   <= t;
		p1_s2  <= dx_s1 * ady_s1;
		p2_s2  <= ex_s1 * t_s1;
	end

endmodule
`default_nettype wire

FILE: rtl/core/point_in_polygon_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd ray-casting point-in-polygon test over a ring of vertex cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): operation 0 writes one vertex at
// vertex_index and gives no result; operation 1 queries point (coord_x,
// coord_y) and gives one item on the output channel (out_valid/out_ready).
// vertex_count must be written through cfg_we/cfg_data only while the block
// is idle; the block itself does not enforce this. A write item leaves the
// block idle. A query rotates the 64-cell vertex ring one full turn, one edge
// per cycle into a three-stage crossing unit, then runs the closing edge and
// a drain; out_valid rises after the drain once the output register is free.
// A new item is taken only while no query is running.
// The result sits in an output register; the block goes back to idle and
// takes new items while it waits. A second query finishing while the
// receiver stalls holds until the output register is free.
// Reset clears vertex_count, the sequencer and the output valid; vertex cells
// are undefined until written.
// ----------------------------------------------------------------------------
module point_in_polygon_test
	import pip_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [CNT_BITS-1:0]          cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         operation,
	input  wire logic [IDX_BITS-1:0]          vertex_index,
	input  wire logic signed [COORD_BITS-1:0] coord_x,
	input  wire logic signed [COORD_BITS-1:0] coord_y,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              inside_res
);

	pip_state_t state_q, state_d;

	logic [CNT_BITS-1:0]          vertex_count_q;
	logic [CNT_BITS-1:0]          n_eff;
	logic [IDX_BITS-1:0]          step_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	vertex_t                      v0_q, prev_q;
	vertex_t                      ring_q [MAX_VERTICES];
	vertex_t                      head;
	vertex_t                      edge_i;
	vertex_t                      wr_data;
	edge_ctl_t                    edge_ctl;
	logic                         parity;
	logic                         in_acc, wr_acc, q_acc;
	logic                         shift_en, out_load, out_valid_q;
	logic                         step_in_use, scan_last, drain_last;

	assign n_eff   = (vertex_count_q > CNT_BITS'(MAX_VERTICES)) ? CNT_BITS'(MAX_VERTICES)
	                                                            : vertex_count_q;
	assign head    = ring_q[0];
	assign wr_data = '{x: coord_x, y: coord_y};

	assign in_acc      = in_valid && in_ready;
	assign wr_acc      = in_acc && (operation == OP_WRITE);
	assign q_acc       = in_acc && (operation == OP_QUERY);
	assign step_in_use = CNT_BITS'(step_q) < n_eff;
	assign scan_last   = step_q == IDX_BITS'(MAX_VERTICES - 1);
	assign drain_last  = step_q == IDX_BITS'(2);

	// vertex ring
	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
		pip_cell u_cell (
			.clk       (clk),
			.load_en   (wr_acc && (vertex_index == IDX_BITS'(k))),
			.load_data (wr_data),
			.shift_en  (shift_en),
			.shift_in  (ring_q[(k + 1) % MAX_VERTICES]),
			.vertex_q  (ring_q[k])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_acc) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_CLOSE;
			end
			ST_CLOSE: begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready       = 1'b0;
		shift_en       = 1'b0;
		edge_ctl.valid = 1'b0;
		edge_ctl.clear = 1'b0;
		edge_i         = head;
		out_load       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				edge_ctl.clear = q_acc;
			end
			ST_SCAN: begin
				shift_en       = 1'b1;
				edge_ctl.valid = step_in_use && (step_q != '0);
			end
			ST_CLOSE: begin
				edge_i         = v0_q;
				edge_ctl.valid = n_eff != '0;
			end
			ST_DRAIN: begin
				out_load = drain_last && (!out_valid_q || out_ready);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	pip_edge u_edge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (edge_ctl),
		.vert_i   (edge_i),
		.vert_j   (prev_q),
		.px       (px_q),
		.py       (py_q),
		.parity_q (parity)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vertex_count_q <= '0;
			step_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) vertex_count_q <= cfg_data;
			case (state_q)
				ST_IDLE:  step_q <= '0;
				ST_SCAN:  step_q <= scan_last ? '0 : step_q + IDX_BITS'(1);
				ST_CLOSE: step_q <= '0;
				ST_DRAIN: step_q <= drain_last ? step_q : step_q + IDX_BITS'(1);
				default:  step_q <= '0;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// query point, first vertex and previous vertex
	always_ff @(posedge clk) begin
		if (q_acc) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if ((state_q == ST_SCAN) && (step_q == '0)) v0_q <= head;
		if ((state_q == ST_SCAN) && step_in_use) prev_q <= head;
		if (out_load) inside_res <= parity;
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the point-in-polygon test: vertex writes and point
// queries go in over a valid/ready channel, inside/outside answers come back
// and are checked against an exact even-odd crossing count kept in the bench.
// Runs a directed set, then random polygons under several vertex counts and
// idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb;
	import pip_pkg::*;

	localparam int SETTLE       = 80;
	localparam int QUIET_LIMIT  = 4000;
	localparam int NUM_PHASES   = 24;
	localparam int PHASE_ITEMS  = 80;
	localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	typedef struct {
		logic                         op;
		logic [IDX_BITS-1:0]          idx;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} pip_item_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [CNT_BITS-1:0]          cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         operation = OP_WRITE;
	logic [IDX_BITS-1:0]          vertex_index = '0;
	logic signed [COORD_BITS-1:0] coord_x = '0;
	logic signed [COORD_BITS-1:0] coord_y = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic                         inside_res;

	pip_item_t item_q[$];
	logic      verdict_q[$];

	// bench-side polygon copy used for prediction
	logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
	int                           poly_count = 0;

	// polygon as the stimulus generator last wrote it
	logic signed [COORD_BITS-1:0] gen_x [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] gen_y [MAX_VERTICES];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errs = 0;
	int quiet_cycles = 0;

	point_in_polygon_test uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.inside_res   (inside_res)
	);

	always #4 clk = ~clk;

	// exact even-odd crossing count over edges (i, i-1 cyclic)
	function automatic logic ray_parity(longint px, longint py);
		int     n, i, j;
		logic   par;
		longint xi, yi, xj, yj, dy, ady, t;
		n = (poly_count > MAX_VERTICES) ? MAX_VERTICES : poly_count;
		par = 1'b0;
		if (n == 0)
			return 1'b0;
		j = n - 1;
		for (i = 0; i < n; i++) begin
			xi = poly_x[i];
			yi = poly_y[i];
			xj = poly_x[j];
			yj = poly_y[j];
			if ((yi > py) != (yj > py)) begin
				dy = yj - yi;
				ady = (dy < 0) ? -dy : dy;
				t = (dy < 0) ? yi - py : py - yi;
				if ((px - xi) * ady < (xj - xi) * t)
					par = ~par;
			end
			j = i;
		end
		return par;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] coord_near(longint c, longint s);
		return COORD_BITS'(c + longint'($urandom_range(0, 32'(2 * s))) - s);
	endfunction

	task automatic push_item(input logic op, input int idx,
			input logic signed [COORD_BITS-1:0] x, input logic signed [COORD_BITS-1:0] y);
		pip_item_t it;
		it.op = op;
		it.idx = IDX_BITS'(idx);
		it.x = x;
		it.y = y;
		if (op == OP_WRITE) begin
			gen_x[idx] = x;
			gen_y[idx] = y;
		end
		item_q = {item_q, it};
	endtask

	task automatic drain_and_settle();
		while (item_q.size() != 0 || in_valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_count(input int v);
		drain_and_settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= CNT_BITS'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		poly_count = v;
	endtask

	task automatic random_phase(input int k);
		int     cnt, n, extra, r, v, w, i;
		longint sc, lim, cx, cy;
		logic signed [COORD_BITS-1:0] qx, qy;
		case (k % 8)
			0: cnt = 3;
			1: cnt = $urandom_range(4, 10);
			2: cnt = MAX_VERTICES;
			3: cnt = $urandom_range(MAX_VERTICES + 1, 127);
			4: cnt = $urandom_range(3, 16);
			5: cnt = 127;
			6: cnt = $urandom_range(0, 2);
			default: cnt = $urandom_range(17, 63);
		endcase
		set_count(cnt);
		case (k % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
			default: begin send_idle_pct = 30; recv_stall_pct = 30; end
		endcase
		n = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
		case ($urandom_range(0, 3))
			0: sc = 15;
			1: sc = 1000;
			2: sc = 1 << 20;
			default: sc = longint'(C_MAX);
		endcase
		lim = longint'(C_MAX) - sc;
		cx = longint'($urandom_range(0, 32'(2 * lim))) - lim;
		cy = longint'($urandom_range(0, 32'(2 * lim))) - lim;
		// fresh polygon over every slot in use
		for (i = 0; i < n; i++)
			push_item(OP_WRITE, i, coord_near(cx, sc), coord_near(cy, sc));
		extra = PHASE_ITEMS - n;
		if (extra < 16)
			extra = 16;
		for (i = 0; i < extra; i++) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				push_item(OP_WRITE, $urandom_range(0, MAX_VERTICES - 1),
					coord_near(cx, sc), coord_near(cy, sc));
			end else begin
				v = (n > 0) ? $urandom_range(0, n - 1) : 0;
				w = (v == 0) ? n - 1 : v - 1;
				r = $urandom_range(0, 99);
				if (r >= 85) begin
					qx = COORD_BITS'($urandom());
					qy = COORD_BITS'($urandom());
				end else if (n == 0 || r < 40) begin
					qx = coord_near(cx, sc);
					qy = coord_near(cy, sc);
				end else if (r < 55) begin
					qx = coord_near(cx, sc);
					qy = gen_y[v];
				end else if (r < 65) begin
					qx = gen_x[v];
					qy = gen_y[v];
				end else if (r < 75) begin
					qx = gen_x[v];
					qy = coord_near(cy, sc);
				end else begin
					qx = COORD_BITS'((longint'(gen_x[v]) + longint'(gen_x[w])) / 2);
					qy = COORD_BITS'((longint'(gen_y[v]) + longint'(gen_y[w])) / 2);
				end
				push_item(OP_QUERY, $urandom_range(0, MAX_VERTICES - 1), qx, qy);
			end
		end
	endtask

	// driver: present the next item once the current one is taken
	always @(posedge clk) begin
		pip_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				it = item_q.pop_front();
				if (it.op == OP_WRITE) begin
					poly_x[it.idx] = it.x;
					poly_y[it.idx] = it.y;
				end else begin
					verdict_q = {verdict_q, ray_parity(it.x, it.y)};
				end
				in_valid <= 1'b1;
				operation <= it.op;
				vertex_index <= it.idx;
				coord_x <= it.x;
				coord_y <= it.y;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check each accepted result, then pick the next ready
	always @(posedge clk) begin
		logic exp_in;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %0b",
						$time, inside_res);
					errs++;
				end else begin
					exp_in = verdict_q.pop_front();
					if (inside_res !== exp_in) begin
						$display("%0t: inside_res mismatch, expected %0b, got %0b",
							$time, exp_in, inside_res);
						errs++;
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// count still zero from reset: square at the coordinate extremes
		push_item(OP_WRITE, 0, C_MIN, C_MIN);
		push_item(OP_WRITE, 1, C_MAX, C_MIN);
		push_item(OP_WRITE, 2, C_MAX, C_MAX);
		push_item(OP_WRITE, 3, C_MIN, C_MAX);
		push_item(OP_WRITE, MAX_VERTICES - 1, C_MIN, C_MAX);
		push_item(OP_QUERY, 0, '0, '0);
		push_item(OP_QUERY, MAX_VERTICES - 1, C_MAX, C_MAX);

		// full square, points inside, on vertices and on edges
		set_count(4);
		push_item(OP_QUERY, 0, '0, '0);
		push_item(OP_QUERY, 0, C_MIN, C_MIN);
		push_item(OP_QUERY, 0, C_MAX, C_MAX);
		push_item(OP_QUERY, 0, '0, C_MIN);
		push_item(OP_QUERY, 0, C_MIN, '0);
		push_item(OP_QUERY, 0, C_MAX, '0);
		push_item(OP_QUERY, 0, '0, C_MAX);
		push_item(OP_QUERY, 0, -24'sd1, -24'sd1);

		// degenerate polygons
		set_count(1);
		push_item(OP_QUERY, 0, '0, '0);
		set_count(2);
		push_item(OP_QUERY, 0, '0, '0);
		push_item(OP_QUERY, 0, C_MIN, '0);

		for (k = 0; k < NUM_PHASES; k++)
			random_phase(k);

		drain_and_settle();
		if (errs == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
